FILE: hdl/rpf_pkg.sv
package rpf_pkg;

   // Packet store geometry
   localparam int STORE_BYTES = 64;
   localparam int BEAT_COUNT  = 8;
   localparam int BEAT_BITS   = 64;
   localparam int OFF_W       = $clog2(STORE_BYTES);
   localparam int BEAT_W      = $clog2(BEAT_COUNT);

   // Header sizes
   localparam int INIT_HDR = 7;
   localparam int CONT_HDR = 5;

   // Packet counter saturation
   localparam int CNT_MAX = 255;

   // Defaults for top-level parameters
   localparam int DEF_PACKET_BYTES = 64;
   localparam int DEF_MAX_SEQ      = 127;

   // Request command codes
   localparam logic [1:0] CMD_BYTE  = 2'd0;
   localparam logic [1:0] CMD_LAST  = 2'd1;
   localparam logic [1:0] CMD_EMPTY = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   typedef logic [STORE_BYTES-1:0][7:0] store_type;

   // Builder to drain handoff
   typedef struct packed {
      logic      load;
      logic      seq_err;
      store_type data;
   } emit_type;

endpackage

FILE: hdl/rpf_builder.sv
module rpf_builder
   import rpf_pkg::*;
#(
   parameter int PACKET_BYTES = DEF_PACKET_BYTES,
   parameter int MAX_SEQ      = DEF_MAX_SEQ
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_data_byte,
   input  logic [31:0] req_channel_id,
   input  logic [7:0]  req_message_cmd,
   input  logic [12:0] req_message_len,
   input  logic        drain_free,
   output emit_type    emit
);

   localparam logic [7:0] SeqLimit = 8'(MAX_SEQ + 1);

   store_type        store_ff, store_in, store_new;
   logic [OFF_W-1:0] off_ff, off_in;
   logic [7:0]       cnt_ff, cnt_in;
   logic             drop_ff, drop_in;

   logic             hdr_needed, init_pkt, seq_over, active;
   logic             is_app, is_flush, err, hdr_write, byte_write, full, pkt;
   logic             will_emit, accept;
   logic [OFF_W-1:0] pos;
   logic [OFF_W:0]   off_after;

   // Decode of the incoming transaction against current state
   always_comb begin
      hdr_needed = (off_ff == '0);
      init_pkt   = (cnt_ff == '0);
      seq_over   = (cnt_ff > SeqLimit);
      is_app     = (req_command == CMD_BYTE) || (req_command == CMD_LAST);
      is_flush   = (req_command == CMD_LAST) || (req_command == CMD_EMPTY);
      active     = (req_command != CMD_NONE) && !drop_ff;
      err        = active && hdr_needed && seq_over;
      hdr_write  = active && hdr_needed && !seq_over;
      if (!hdr_needed) begin
         pos = off_ff;
      end else if (init_pkt) begin
         pos = OFF_W'(INIT_HDR);
      end else begin
         pos = OFF_W'(CONT_HDR);
      end
      byte_write = active && is_app && !err;
      off_after  = {1'b0, pos} + {{OFF_W{1'b0}}, 1'b1};
      full       = byte_write && (off_after >= (OFF_W+1)'(PACKET_BYTES));
      pkt        = active && !err && (is_flush || full);
      will_emit  = err || pkt;
      req_ready  = !will_emit || drain_free;
      accept     = req_valid && req_ready;
   end

   // Store contents after header and byte writes
   always_comb begin
      store_new = store_ff;
      if (hdr_write) begin
         store_new[0] = req_channel_id[31:24];
         store_new[1] = req_channel_id[23:16];
         store_new[2] = req_channel_id[15:8];
         store_new[3] = req_channel_id[7:0];
         if (init_pkt) begin
            store_new[4] = req_message_cmd;
            store_new[5] = {3'b000, req_message_len[12:8]};
            store_new[6] = req_message_len[7:0];
         end else begin
            store_new[4] = cnt_ff - 8'd1;
         end
      end
      for (int i = 0; i < STORE_BYTES; i++) begin
         if (byte_write && (pos == OFF_W'(i))) begin
            store_new[i] = req_data_byte;
         end
      end
   end

   // Next state
   always_comb begin
      store_in = store_ff;
      off_in   = off_ff;
      cnt_in   = cnt_ff;
      drop_in  = drop_ff;
      if (accept) begin
         if (is_flush) begin
            store_in = '0;
            off_in   = '0;
            cnt_in   = '0;
            drop_in  = 1'b0;
         end else if (err) begin
            drop_in = 1'b1;
         end else if (active) begin
            if (full) begin
               store_in = '0;
               off_in   = '0;
               if (cnt_ff != 8'(CNT_MAX)) begin
                  cnt_in = cnt_ff + 8'd1;
               end
            end else begin
               store_in = store_new;
               off_in   = off_after[OFF_W-1:0];
            end
         end
      end
   end

   // Handoff to the drain buffer
   always_comb begin
      emit.load    = accept && will_emit;
      emit.seq_err = err;
      emit.data    = err ? '0 : store_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
         off_ff   <= '0;
         cnt_ff   <= '0;
         drop_ff  <= 1'b0;
      end else begin
         store_ff <= store_in;
         off_ff   <= off_in;
         cnt_ff   <= cnt_in;
         drop_ff  <= drop_in;
      end
   end

endmodule

FILE: hdl/rpf_drain.sv
module rpf_drain
   import rpf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  emit_type             emit,
   output logic                 drain_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BEAT_BITS-1:0] rsp_beat_data,
   output logic [BEAT_W-1:0]    rsp_beat_index,
   output logic                 rsp_beat_last,
   output logic                 rsp_seq_error
);

   logic [BEAT_COUNT-1:0][BEAT_BITS-1:0] rows_ff, rows_in;
   logic                                 busy_ff, busy_in;
   logic                                 err_ff, err_in;
   logic [BEAT_W-1:0]                    beat_ff, beat_in;
   logic                                 take;

   // Output view: beat 0 of the shift line
   always_comb begin
      rsp_valid      = busy_ff;
      rsp_beat_data  = rows_ff[0];
      rsp_beat_index = beat_ff;
      rsp_beat_last  = err_ff || (beat_ff == BEAT_W'(BEAT_COUNT - 1));
      rsp_seq_error  = err_ff;
      take           = busy_ff && rsp_ready;
      drain_free     = !busy_ff || (take && rsp_beat_last);
   end

   // Load a packet or shift out one beat per transaction
   always_comb begin
      rows_in = rows_ff;
      busy_in = busy_ff;
      err_in  = err_ff;
      beat_in = beat_ff;
      if (emit.load) begin
         rows_in = emit.data;
         busy_in = 1'b1;
         err_in  = emit.seq_err;
         beat_in = '0;
      end else if (take) begin
         if (rsp_beat_last) begin
            busy_in = 1'b0;
         end else begin
            beat_in = beat_ff + BEAT_W'(1);
            for (int k = 0; k < BEAT_COUNT - 1; k++) begin
               rows_in[k] = rows_ff[k+1];
            end
            rows_in[BEAT_COUNT-1] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         err_ff  <= 1'b0;
         beat_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         err_ff  <= err_in;
         beat_ff <= beat_in;
      end
      rows_ff <= rows_in;
   end

endmodule

FILE: hdl/hid_response_packet_framer_top.sv
// The beats of a packet start in the cycle after the transaction that completes or flushes it.
// Throughput: one request transaction per cycle unless stalled; a packet drains as eight
// beats, one per cycle while rsp_ready is high. The request side stalls only when a packet
// or error is ready while the previous packet's beats still occupy the single drain buffer.
// Reset: synchronous, active high; clears the packet store to zero and all counters and flags.
module hid_response_packet_framer_top
   import rpf_pkg::*;
#(
   parameter int PACKET_BYTES = DEF_PACKET_BYTES,
   parameter int MAX_SEQ      = DEF_MAX_SEQ
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_command,
   input  logic [7:0]           req_data_byte,
   input  logic [31:0]          req_channel_id,
   input  logic [7:0]           req_message_cmd,
   input  logic [12:0]          req_message_len,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BEAT_BITS-1:0] rsp_beat_data,
   output logic [BEAT_W-1:0]    rsp_beat_index,
   output logic                 rsp_beat_last,
   output logic                 rsp_seq_error
);

   emit_type emit;
   logic     drain_free;

   rpf_builder #(
      .PACKET_BYTES (PACKET_BYTES),
      .MAX_SEQ      (MAX_SEQ)
   ) u_builder (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_data_byte   (req_data_byte),
      .req_channel_id  (req_channel_id),
      .req_message_cmd (req_message_cmd),
      .req_message_len (req_message_len),
      .drain_free      (drain_free),
      .emit            (emit)
   );

   rpf_drain u_drain (
      .clock          (clock),
      .reset          (reset),
      .emit           (emit),
      .drain_free     (drain_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_beat_data  (rsp_beat_data),
      .rsp_beat_index (rsp_beat_index),
      .rsp_beat_last  (rsp_beat_last),
      .rsp_seq_error  (rsp_seq_error)
   );

`ifndef ASSERT_OFF
   // Error transaction is a single zero beat
   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_seq_error |->
         rsp_beat_last && (rsp_beat_data == '0) && (rsp_beat_index == '0))
      else $error("error result is not a single zero beat");

   // Beats of a packet follow in order
   a_beat_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_beat_last |=>
         rsp_valid && (rsp_beat_index == BEAT_W'($past(rsp_beat_index) + 1'b1)))
      else $error("packet beat sequence broken");

   // Drain buffer is never overwritten while beats remain
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      emit.load |-> drain_free)
      else $error("drain buffer loaded while busy");
`endif

endmodule

FILE: sim/rpf_beat_checker.sv
// Watches both channels of the packet framer, predicts the beats that each
// request transaction causes and compares every response transaction with
// the oldest beat still expected.
module rpf_beat_checker
   import rpf_pkg::*;
#(
   parameter int PACKET_BYTES = DEF_PACKET_BYTES,
   parameter int MAX_SEQ      = DEF_MAX_SEQ
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [1:0]           req_command,
   input  logic [7:0]           req_data_byte,
   input  logic [31:0]          req_channel_id,
   input  logic [7:0]           req_message_cmd,
   input  logic [12:0]          req_message_len,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [BEAT_BITS-1:0] rsp_beat_data,
   input  logic [BEAT_W-1:0]    rsp_beat_index,
   input  logic                 rsp_beat_last,
   input  logic                 rsp_seq_error,
   output int                   mismatch_count,
   output int                   beats_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [BEAT_BITS-1:0] data;
      logic [BEAT_W-1:0]    index;
      logic                 last;
      logic                 seq_err;
   } beat_type;

   beat_type    expected_beats[$];

   // Shadow of the packet under construction
   logic [7:0]  frame_bytes[STORE_BYTES];
   int unsigned fill_pos;
   int unsigned packets_sent;
   bit          dropping;

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
      mismatch_count++;
   endtask

   function automatic void clear_frame();
      for (int i = 0; i < STORE_BYTES; i++) frame_bytes[i] = 8'h00;
   endfunction

   // Queue the eight beats of the current packet, then empty the store
   function automatic void emit_frame();
      beat_type b;
      for (int k = 0; k < BEAT_COUNT; k++) begin
         for (int j = 0; j < 8; j++) b.data[8*j +: 8] = frame_bytes[8*k + j];
         b.index   = BEAT_W'(k);
         b.last    = (k == BEAT_COUNT - 1);
         b.seq_err = 1'b0;
         expected_beats.push_back(b);
      end
      clear_frame();
   endfunction

   function automatic void flag_overflow();
      beat_type b;
      b.data    = '0;
      b.index   = '0;
      b.last    = 1'b1;
      b.seq_err = 1'b1;
      expected_beats.push_back(b);
      dropping = 1'b1;
   endfunction

   // Write a header when the packet is still empty; 0 on sequence overflow
   function automatic bit open_header(input logic [31:0] cid, input logic [7:0] mcmd,
                                      input logic [12:0] mlen);
      if (fill_pos != 0) return 1'b1;
      if (packets_sent != 0 && packets_sent - 1 > MAX_SEQ) return 1'b0;
      frame_bytes[0] = cid[31:24];
      frame_bytes[1] = cid[23:16];
      frame_bytes[2] = cid[15:8];
      frame_bytes[3] = cid[7:0];
      if (packets_sent == 0) begin
         frame_bytes[4] = mcmd;
         frame_bytes[5] = {3'b000, mlen[12:8]};
         frame_bytes[6] = mlen[7:0];
         fill_pos = INIT_HDR;
      end else begin
         frame_bytes[4] = 8'(packets_sent - 1);
         fill_pos = CONT_HDR;
      end
      return 1'b1;
   endfunction

   function automatic void append_payload(input logic [7:0] data, input logic [31:0] cid,
                                          input logic [7:0] mcmd, input logic [12:0] mlen);
      if (dropping) return;
      if (!open_header(cid, mcmd, mlen)) begin
         flag_overflow();
         return;
      end
      if (fill_pos < PACKET_BYTES && fill_pos < STORE_BYTES) frame_bytes[fill_pos] = data;
      fill_pos++;
      if (fill_pos >= PACKET_BYTES) begin
         emit_frame();
         fill_pos = 0;
         if (packets_sent < CNT_MAX) packets_sent++;
      end
   endfunction

   function automatic void close_message();
      if (fill_pos != 0) emit_frame();
      clear_frame();
      fill_pos     = 0;
      packets_sent = 0;
      dropping     = 1'b0;
   endfunction

   function automatic void predict_request();
      case (req_command)
         CMD_BYTE: begin
            append_payload(req_data_byte, req_channel_id, req_message_cmd, req_message_len);
         end
         CMD_LAST: begin
            append_payload(req_data_byte, req_channel_id, req_message_cmd, req_message_len);
            close_message();
         end
         CMD_EMPTY: begin
            if (!dropping && !open_header(req_channel_id, req_message_cmd, req_message_len))
               flag_overflow();
            close_message();
         end
         default: ;
      endcase
   endfunction

   task automatic check_beat();
      beat_type want;
      if (expected_beats.size() == 0) begin
         report_mismatch("beat with nothing expected", '0, rsp_beat_data);
         return;
      end
      want = expected_beats.pop_front();
      if (rsp_beat_data !== want.data)
         report_mismatch("beat_data", want.data, rsp_beat_data);
      if (rsp_beat_index !== want.index)
         report_mismatch("beat_index", 64'(want.index), 64'(rsp_beat_index));
      if (rsp_beat_last !== want.last)
         report_mismatch("beat_last", 64'(want.last), 64'(rsp_beat_last));
      if (rsp_seq_error !== want.seq_err)
         report_mismatch("seq_error", 64'(want.seq_err), 64'(rsp_seq_error));
   endtask

   // Responses are checked before the request of the same edge is predicted;
   // no beat can leave in the cycle of the transaction that causes it.
   always @(posedge clock) begin
      if (reset) begin
         expected_beats.delete();
         close_message();
      end else begin
         if (rsp_valid && rsp_ready) check_beat();
         if (req_valid && req_ready) predict_request();
      end
      beats_pending <= expected_beats.size();
   end

endmodule

FILE: sim/tb_hid_response_packet_framer_top.sv
module tb_hid_response_packet_framer_top
   import rpf_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_command;
   logic [7:0]           req_data_byte;
   logic [31:0]          req_channel_id;
   logic [7:0]           req_message_cmd;
   logic [12:0]          req_message_len;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [BEAT_BITS-1:0] rsp_beat_data;
   logic [BEAT_W-1:0]    rsp_beat_index;
   logic                 rsp_beat_last;
   logic                 rsp_seq_error;

   int                   mismatch_count;
   int                   beats_pending;
   bit                   steady;

   hid_response_packet_framer_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_data_byte   (req_data_byte),
      .req_channel_id  (req_channel_id),
      .req_message_cmd (req_message_cmd),
      .req_message_len (req_message_len),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_beat_data   (rsp_beat_data),
      .rsp_beat_index  (rsp_beat_index),
      .rsp_beat_last   (rsp_beat_last),
      .rsp_seq_error   (rsp_seq_error)
   );

   rpf_beat_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_data_byte   (req_data_byte),
      .req_channel_id  (req_channel_id),
      .req_message_cmd (req_message_cmd),
      .req_message_len (req_message_len),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_beat_data   (rsp_beat_data),
      .rsp_beat_index  (rsp_beat_index),
      .rsp_beat_last   (rsp_beat_last),
      .rsp_seq_error   (rsp_seq_error),
      .mismatch_count  (mismatch_count),
      .beats_pending   (beats_pending)
   );

   always #5 clock = ~clock;

   initial begin
      #60ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(11, 30);
   endfunction

   // Response side back-pressure
   initial begin
      int run;
      int stall;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         run = $urandom_range(1, 24);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // One request transaction; returns at the edge that accepts it, valid still high
   task automatic send_request(input logic [1:0] cmd, input logic [7:0] data,
                               input logic [31:0] cid, input logic [7:0] mcmd,
                               input logic [12:0] mlen);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_data_byte   <= data;
      req_channel_id  <= cid;
      req_message_cmd <= mcmd;
      req_message_len <= mlen;
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold off the sender until every expected beat has been seen
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (beats_pending != 0) @(posedge clock);
   endtask

   // Random message: payload bytes closed by a final byte or an empty flush,
   // sometimes left open; noise, stray commands and changing header fields mixed in
   task automatic send_random_message(output int counted);
      int          pick;
      int          len;
      logic [1:0]  closer;
      logic [1:0]  cmd;
      logic [31:0] cid;
      logic [7:0]  mcmd;
      logic [12:0] mlen;
      counted = 0;
      pick = $urandom_range(0, 99);
      if (pick < 45) len = $urandom_range(0, 8);
      else if (pick < 75) len = ($urandom_range(0, 1) ? 57 : 116) + $urandom_range(0, 3) - 2;
      else len = $urandom_range(0, 130);
      pick = $urandom_range(0, 99);
      closer = (pick < 45) ? CMD_LAST : (pick < 90) ? CMD_EMPTY : CMD_NONE;
      cid  = $urandom;
      mcmd = 8'($urandom);
      mlen = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 7609))
                                         : 13'(len + (closer == CMD_LAST));
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0)
            send_request(CMD_NONE, 8'($urandom), $urandom, 8'($urandom), mlen);
         cmd = ($urandom_range(0, 32) == 0) ? 2'($urandom_range(0, 3)) : CMD_BYTE;
         if ($urandom_range(0, 9) == 0)
            send_request(cmd, 8'($urandom), $urandom, 8'($urandom),
                         13'($urandom_range(0, 7609)));
         else
            send_request(cmd, 8'($urandom), cid, mcmd, mlen);
         if (cmd != CMD_NONE) counted++;
      end
      if (closer != CMD_NONE) begin
         send_request(closer, 8'($urandom), cid, mcmd, mlen);
         counted++;
      end
   endtask

   // Fill the init packet and every allowed continuation packet, then push
   // one more transaction so the sequence number runs past its limit
   task automatic send_overflow_message(input logic [1:0] ending, input logic [1:0] closer);
      logic [31:0] cid;
      logic [7:0]  mcmd;
      int          fill;
      cid  = $urandom;
      mcmd = 8'($urandom);
      fill = (DEF_PACKET_BYTES - INIT_HDR) + (DEF_MAX_SEQ + 1) * (DEF_PACKET_BYTES - CONT_HDR);
      for (int i = 0; i < fill; i++)
         send_request(CMD_BYTE, 8'($urandom), cid, mcmd, 13'(fill));
      send_request(ending, 8'($urandom), cid, mcmd, 13'(fill));
      if (ending == CMD_BYTE) begin
         // bytes after the error are dropped until the message is closed
         repeat ($urandom_range(1, 4))
            send_request(CMD_BYTE, 8'($urandom), $urandom, 8'($urandom), 13'(fill));
         send_request(closer, 8'($urandom), $urandom, 8'($urandom), 13'(fill));
      end
   endtask

   // Stimulus and verdict
   initial begin
      int random_items;
      int counted;
      int drain_cycles;
      bit paused;
      req_valid       = 1'b0;
      req_command     = CMD_NONE;
      req_data_byte   = 8'h00;
      req_channel_id  = 32'h0;
      req_message_cmd = 8'h00;
      req_message_len = 13'h0;
      steady          = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty messages, single-byte message, ignored commands,
      // header fields changing after the header is written
      send_request(CMD_EMPTY, 8'h00, 32'hFFFF_FFFF, 8'hFF, 13'd7609);
      send_request(CMD_EMPTY, 8'hFF, 32'h0000_0000, 8'h00, 13'd0);
      send_request(CMD_LAST,  8'hFF, 32'h0123_4567, 8'h83, 13'd1);
      send_request(CMD_NONE,  8'hAA, 32'hDEAD_BEEF, 8'h55, 13'd5);
      send_request(CMD_BYTE,  8'h00, 32'h8000_0001, 8'h01, 13'd4096);
      send_request(CMD_NONE,  8'h3C, 32'h1111_1111, 8'h22, 13'd33);
      send_request(CMD_BYTE,  8'hA5, 32'h7FFF_FFFE, 8'hFE, 13'd2047);
      send_request(CMD_LAST,  8'h5A, 32'h0000_0000, 8'h00, 13'd0);
      send_request(CMD_BYTE,  8'h7E, 32'hA5A5_5A5A, 8'h80, 13'd3);
      send_request(CMD_BYTE,  8'h81, 32'h0, 8'h0, 13'd0);
      send_request(CMD_BYTE,  8'hC3, 32'h0, 8'h0, 13'd0);
      send_request(CMD_EMPTY, 8'h00, 32'h0, 8'h0, 13'd0);
      send_request(CMD_NONE,  8'hFF, 32'hFFFF_FFFF, 8'hFF, 13'd7609);
      wait_drained();

      // Random messages
      random_items = 0;
      paused = 1'b0;
      while (random_items < 430) begin
         steady = ($urandom_range(0, 5) == 0);
         send_random_message(counted);
         random_items += counted;
         if (!paused && random_items >= 200) begin
            wait_drained();
            paused = 1'b1;
         end
      end
      steady = 1'b0;
      send_request(CMD_EMPTY, 8'h00, $urandom, 8'($urandom), 13'($urandom_range(0, 7609)));

      // Sequence overflow, ended in each way the message can end
      steady = 1'b1;
      send_overflow_message(CMD_BYTE, CMD_LAST);
      steady = 1'b0;
      send_overflow_message(CMD_BYTE, CMD_EMPTY);
      send_overflow_message(CMD_LAST, CMD_NONE);
      send_overflow_message(CMD_EMPTY, CMD_NONE);
      send_request(CMD_LAST, 8'($urandom), $urandom, 8'($urandom), 13'd1);

      // Drain and verdict
      req_valid <= 1'b0;
      @(posedge clock);
      drain_cycles = 0;
      while (beats_pending != 0 && drain_cycles < 20000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && beats_pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         if (beats_pending != 0) $display("%0d expected beats never arrived", beats_pending);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
